// ===== hw/rtl/esc_rts_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_rts_pkg
// Shared widths, register indexes, reset values, codes and the
// configuration struct of the ESC reverse throttle sequencer.
// ----------------------------------------------------------------------------
package esc_rts_pkg;

    localparam int PW_W       = 12;  // pulse width, us
    localparam int DUR_W      = 16;  // phase durations, ms
    localparam int CH_W       = 4;   // PWM channel
    localparam int TIME_W     = 32;  // millisecond timestamp
    localparam int Q_W        = 16;  // Q2.14 throttle
    localparam int Q_FRAC     = 14;
    localparam int MAG_W      = Q_FRAC + 1;  // magnitude 0..1.0 inclusive
    localparam int PH_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [Q_W-1:0] Q_ONE     = 16'sd16384;
    localparam logic signed [Q_W-1:0] Q_NEG_ONE = -16'sd16384;

    // opcodes
    localparam logic OP_THROTTLE = 1'b0;
    localparam logic OP_STOP     = 1'b1;

    // reverse sequence phases
    localparam logic [PH_W-1:0] PH_READY   = 2'd0;
    localparam logic [PH_W-1:0] PH_BRAKE   = 2'd1;
    localparam logic [PH_W-1:0] PH_PAUSE   = 2'd2;
    localparam logic [PH_W-1:0] PH_ENGAGED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_CREEP_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_MAX_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_CREEP_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MAX_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_TIME_MS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME_MS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNEL         = 3'd7;

    // reset values
    localparam logic [PW_W-1:0]  RST_NEUTRAL_WIDTH       = 12'd1500;
    localparam logic [PW_W-1:0]  RST_FORWARD_CREEP_WIDTH = 12'd1550;
    localparam logic [PW_W-1:0]  RST_FORWARD_MAX_WIDTH   = 12'd2000;
    localparam logic [PW_W-1:0]  RST_REVERSE_CREEP_WIDTH = 12'd1450;
    localparam logic [PW_W-1:0]  RST_REVERSE_MAX_WIDTH   = 12'd1000;
    localparam logic [DUR_W-1:0] RST_BRAKE_TIME_MS       = 16'd100;
    localparam logic [DUR_W-1:0] RST_PAUSE_TIME_MS       = 16'd100;
    localparam logic [CH_W-1:0]  RST_OUT_CHANNEL         = 4'd0;

    typedef struct packed {
        logic [PW_W-1:0]  neutral_width;
        logic [PW_W-1:0]  forward_creep_width;
        logic [PW_W-1:0]  forward_max_width;
        logic [PW_W-1:0]  reverse_creep_width;
        logic [PW_W-1:0]  reverse_max_width;
        logic [DUR_W-1:0] brake_time_ms;
        logic [DUR_W-1:0] pause_time_ms;
        logic [CH_W-1:0]  out_channel;
    } cfg_t;

endpackage

// ===== hw/rtl/esc_rts_if.sv =====
// ----------------------------------------------------------------------------
// esc_rts_if
// Valid/ready channels of the sequencer: command in, pulse result out.
// ----------------------------------------------------------------------------
interface esc_rts_cmd_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    opcode;
    logic signed [esc_rts_pkg::Q_W-1:0]      throttle_q14;
    logic        [esc_rts_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output opcode, output throttle_q14, output now_ms,
                    input ready);
    modport sink   (input valid, input opcode, input throttle_q14, input now_ms,
                    output ready);
endinterface

interface esc_rts_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [esc_rts_pkg::CH_W-1:0]          channel;
    logic [esc_rts_pkg::PW_W-1:0]          pulse_width;
    logic [esc_rts_pkg::PH_W-1:0]          reverse_phase;

    modport source (output valid, output channel, output pulse_width, output reverse_phase,
                    input ready);
    modport sink   (input valid, input channel, input pulse_width, input reverse_phase,
                    output ready);
endinterface

// ===== hw/rtl/esc_reverse_throttle_sequencer.sv =====
// ----------------------------------------------------------------------------
// esc_reverse_throttle_sequencer
// Throttle commands to ESC pulse widths with a timed brake, neutral pause
// and reverse engage sequence.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  handshake
//  cmd      in   opcode, throttle_q14, now_ms             valid/ready
//  res      out  channel, pulse_width, reverse_phase      valid/ready
//  cfg      in   cfg_index, cfg_wdata                     cfg_we, no wait
//
//  One item per cycle sustained while the result is not stalled; an item
//  goes input register -> result register, and res.valid is registered
//  together with the result. The phase state is updated as an item
//  moves into the result register, so the following item sees it directly.
//  Reset clears valids and phase state and loads register defaults. A stalled
//  result holds; an empty input register still takes one item, then cmd stalls.
// ----------------------------------------------------------------------------
module esc_reverse_throttle_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    esc_rts_cmd_if.sink                          cmd,
    esc_rts_res_if.source                        res,
    input  logic                                 cfg_we,
    input  logic [esc_rts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [esc_rts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    esc_rts_pkg::cfg_t cfg;

    // input register
    logic                                   s1_valid_reg;
    logic                                   s1_opcode_reg;
    logic signed [esc_rts_pkg::Q_W-1:0]     s1_throttle_reg;
    logic [esc_rts_pkg::TIME_W-1:0]         s1_now_reg;

    // result register
    logic                                   out_valid_reg;
    logic [esc_rts_pkg::CH_W-1:0]           out_channel_reg;
    logic [esc_rts_pkg::PW_W-1:0]           out_pulse_reg;
    logic [esc_rts_pkg::PH_W-1:0]           out_phase_reg;

    // sequence state
    logic [esc_rts_pkg::PH_W-1:0]           phase_reg;
    logic [esc_rts_pkg::PH_W-1:0]           phase_next;
    logic [esc_rts_pkg::TIME_W-1:0]         start_reg;
    logic [esc_rts_pkg::TIME_W-1:0]         start_next;

    logic                                   out_free;
    logic                                   advance;
    logic                                   take;

    logic signed [esc_rts_pkg::Q_W-1:0]     thr_sat;
    logic signed [esc_rts_pkg::Q_W-1:0]     thr_abs;
    logic [esc_rts_pkg::MAG_W-1:0]          mag;
    logic [esc_rts_pkg::TIME_W-1:0]         elapsed;
    logic [esc_rts_pkg::TIME_W-1:0]         el_brake;
    logic [esc_rts_pkg::TIME_W-1:0]         el_pause;
    logic [esc_rts_pkg::TIME_W-1:0]         brake_lim;
    logic [esc_rts_pkg::TIME_W-1:0]         pause_lim;
    logic [esc_rts_pkg::PH_W-1:0]           ph;
    logic                                   held;
    logic [esc_rts_pkg::PW_W-1:0]           interp_from;
    logic [esc_rts_pkg::PW_W-1:0]           interp_to;
    logic [esc_rts_pkg::PW_W-1:0]           interp_width;
    logic [esc_rts_pkg::PW_W-1:0]           pulse;

    esc_rts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    esc_rts_interp u_interp (
        .mag        (mag),
        .from_width (interp_from),
        .to_width   (interp_to),
        .width      (interp_width)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign take      = cmd.valid && cmd.ready;

    // saturate and take the magnitude
    always_comb
    begin
        if (s1_throttle_reg > esc_rts_pkg::Q_ONE)
            thr_sat = esc_rts_pkg::Q_ONE;
        else if (s1_throttle_reg < esc_rts_pkg::Q_NEG_ONE)
            thr_sat = esc_rts_pkg::Q_NEG_ONE;
        else
            thr_sat = s1_throttle_reg;
        thr_abs = thr_sat[esc_rts_pkg::Q_W-1] ? -thr_sat : thr_sat;
        mag     = thr_abs[esc_rts_pkg::MAG_W-1:0];
    end

    assign elapsed   = s1_now_reg - start_reg;
    assign brake_lim = {{(esc_rts_pkg::TIME_W - esc_rts_pkg::DUR_W){1'b0}}, cfg.brake_time_ms};
    assign pause_lim = {{(esc_rts_pkg::TIME_W - esc_rts_pkg::DUR_W){1'b0}}, cfg.pause_time_ms};

    always_comb
    begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        pulse       = cfg.neutral_width;
        interp_from = cfg.forward_creep_width;
        interp_to   = cfg.forward_max_width;
        ph          = phase_reg;
        held        = 1'b0;
        el_brake    = elapsed;
        el_pause    = elapsed;

        if (s1_opcode_reg == esc_rts_pkg::OP_STOP)
        begin
            phase_next = esc_rts_pkg::PH_READY;
        end
        else if (thr_sat == '0)
        begin
            if (phase_reg == esc_rts_pkg::PH_PAUSE)
            begin
                if (elapsed >= pause_lim)
                    phase_next = esc_rts_pkg::PH_ENGAGED;
            end
            else if (phase_reg != esc_rts_pkg::PH_ENGAGED)
            begin
                phase_next = esc_rts_pkg::PH_READY;
            end
        end
        else if (!thr_sat[esc_rts_pkg::Q_W-1])
        begin
            phase_next = esc_rts_pkg::PH_READY;
            pulse      = interp_width;
        end
        else
        begin
            interp_from = cfg.reverse_creep_width;
            interp_to   = cfg.reverse_max_width;
            // a phase entered in this item starts its timer at now
            if (ph == esc_rts_pkg::PH_READY)
            begin
                ph         = esc_rts_pkg::PH_BRAKE;
                start_next = s1_now_reg;
                el_brake   = '0;
            end
            if (ph == esc_rts_pkg::PH_BRAKE)
            begin
                if (el_brake < brake_lim)
                begin
                    pulse = cfg.reverse_creep_width;
                    held  = 1'b1;
                end
                else
                begin
                    ph         = esc_rts_pkg::PH_PAUSE;
                    start_next = s1_now_reg;
                    el_pause   = '0;
                end
            end
            if (!held && ph == esc_rts_pkg::PH_PAUSE)
            begin
                if (el_pause < pause_lim)
                begin
                    pulse = cfg.neutral_width;
                    held  = 1'b1;
                end
                else
                begin
                    ph = esc_rts_pkg::PH_ENGAGED;
                end
            end
            if (!held)
                pulse = interp_width;
            phase_next = ph;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= esc_rts_pkg::PH_READY;
            start_reg     <= '0;
        end
        else
        begin
            if (cmd.ready)
                s1_valid_reg <= cmd.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (advance)
            begin
                phase_reg <= phase_next;
                start_reg <= start_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_opcode_reg   <= cmd.opcode;
            s1_throttle_reg <= cmd.throttle_q14;
            s1_now_reg      <= cmd.now_ms;
        end
        if (advance)
        begin
            out_channel_reg <= cfg.out_channel;
            out_pulse_reg   <= pulse;
            out_phase_reg   <= phase_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.channel       = out_channel_reg;
    assign res.pulse_width   = out_pulse_reg;
    assign res.reverse_phase = out_phase_reg;

endmodule

// ===== hw/rtl/esc_rts_cfg.sv =====
// ----------------------------------------------------------------------------
// esc_rts_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module esc_rts_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [esc_rts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esc_rts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output esc_rts_pkg::cfg_t                     cfg
);

    esc_rts_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral_width       <= esc_rts_pkg::RST_NEUTRAL_WIDTH;
            cfg_reg.forward_creep_width <= esc_rts_pkg::RST_FORWARD_CREEP_WIDTH;
            cfg_reg.forward_max_width   <= esc_rts_pkg::RST_FORWARD_MAX_WIDTH;
            cfg_reg.reverse_creep_width <= esc_rts_pkg::RST_REVERSE_CREEP_WIDTH;
            cfg_reg.reverse_max_width   <= esc_rts_pkg::RST_REVERSE_MAX_WIDTH;
            cfg_reg.brake_time_ms       <= esc_rts_pkg::RST_BRAKE_TIME_MS;
            cfg_reg.pause_time_ms       <= esc_rts_pkg::RST_PAUSE_TIME_MS;
            cfg_reg.out_channel         <= esc_rts_pkg::RST_OUT_CHANNEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esc_rts_pkg::REG_NEUTRAL_WIDTH:
                    cfg_reg.neutral_width <= cfg_wdata[esc_rts_pkg::PW_W-1:0];
                esc_rts_pkg::REG_FORWARD_CREEP_WIDTH:
                    cfg_reg.forward_creep_width <= cfg_wdata[esc_rts_pkg::PW_W-1:0];
                esc_rts_pkg::REG_FORWARD_MAX_WIDTH:
                    cfg_reg.forward_max_width <= cfg_wdata[esc_rts_pkg::PW_W-1:0];
                esc_rts_pkg::REG_REVERSE_CREEP_WIDTH:
                    cfg_reg.reverse_creep_width <= cfg_wdata[esc_rts_pkg::PW_W-1:0];
                esc_rts_pkg::REG_REVERSE_MAX_WIDTH:
                    cfg_reg.reverse_max_width <= cfg_wdata[esc_rts_pkg::PW_W-1:0];
                esc_rts_pkg::REG_BRAKE_TIME_MS:
                    cfg_reg.brake_time_ms <= cfg_wdata[esc_rts_pkg::DUR_W-1:0];
                esc_rts_pkg::REG_PAUSE_TIME_MS:
                    cfg_reg.pause_time_ms <= cfg_wdata[esc_rts_pkg::DUR_W-1:0];
                esc_rts_pkg::REG_OUT_CHANNEL:
                    cfg_reg.out_channel <= cfg_wdata[esc_rts_pkg::CH_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/esc_rts_interp.sv =====
// ----------------------------------------------------------------------------
// esc_rts_interp
// Linear interpolation from one pulse width to another by a Q1.14
// magnitude, rounded half away from zero.
// ----------------------------------------------------------------------------
module esc_rts_interp (
    input  logic [esc_rts_pkg::MAG_W-1:0] mag,
    input  logic [esc_rts_pkg::PW_W-1:0]  from_width,
    input  logic [esc_rts_pkg::PW_W-1:0]  to_width,
    output logic [esc_rts_pkg::PW_W-1:0]  width
);

    localparam int DIFF_W = esc_rts_pkg::PW_W + 1;
    localparam int PROD_W = esc_rts_pkg::MAG_W + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  base;
    logic signed [NUM_W-1:0]  num;
    logic signed [NUM_W-1:0]  rounded;

    always_comb
    begin
        diff = $signed({1'b0, to_width}) - $signed({1'b0, from_width});
        prod = $signed({1'b0, mag}) * diff;
        base = $signed({{(NUM_W - esc_rts_pkg::PW_W - esc_rts_pkg::Q_FRAC){1'b0}},
                        from_width, {esc_rts_pkg::Q_FRAC{1'b0}}});
        num  = base + $signed({prod[PROD_W-1], prod});
        // num is non-negative, so adding one half and truncating rounds away from zero
        rounded = num + $signed(NUM_W'(1) <<< (esc_rts_pkg::Q_FRAC - 1));
        if (num < 0)
            width = '0;
        else
            width = rounded[esc_rts_pkg::Q_FRAC +: esc_rts_pkg::PW_W];
    end

endmodule
